### rtl/jlvs_pkg.sv
// Shared types and constants for the joint limit velocity scaler.
package jlvs_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TOL_DEG     = 2'd0,
    REG_JOINT_COUNT = 2'd1
  } cfg_reg_t;

  // Degrees (Q8.8) to radians (Q14) scale: 64*pi/180 in Q24
  localparam logic [24:0] TOL_K = 25'd18740330;
  // Tolerance in Q14 radians for the reset value of 10 degrees
  localparam logic [16:0] TOL_RESET = 17'd2860;
  localparam logic [15:0] TOL_DEG_RESET = 16'd2560;
  localparam logic [6:0]  JOINT_COUNT_RESET = 7'd7;

  // Sine polynomial coefficients, Q16
  localparam logic [16:0] C1 = 17'd102944;
  localparam logic [16:0] C3 = 17'd42334;
  localparam logic [16:0] C5 = 17'd5223;
  localparam logic [16:0] C7 = 17'd307;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Divider: 21-bit phase magnitude scaled by 2^16
  localparam int MAG_W  = 21;
  localparam int DIVD_W = 37;

  // Data that rides alongside the phase through the pipeline
  typedef struct packed {
    logic signed [19:0] vel;
    logic               apply;
  } side_t;

endpackage

### rtl/joint_limit_velocity_scaler_core.sv
// Joint limit velocity scaler: zone test, phase divider, sine and power pipeline.
// Pipeline: 1 front stage, 37 divider stages plus fold, 10 multiply stages, with the
// divider resolving one bit per stage.
// Throughput: one transaction per cycle; a stall at the output freezes all stages.
// Reset: synchronous; clears all valid bits, tolerance to 10 degrees, joint count 7.
// Config writes wait for an empty pipeline and stall input until tol is updated.
module joint_limit_velocity_scaler_core #(
  parameter int MAX_JOINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         joint_index,
  input  logic signed [19:0] position,
  input  logic signed [19:0] velocity,
  input  logic signed [19:0] upper_limit,
  input  logic signed [19:0] lower_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] scaled_velocity,
  output logic               was_scaled
);

  localparam logic [6:0] MAXJ = 7'(MAX_JOINTS);

  logic       en;
  logic       tol_pending;
  logic [5:0] in_flight;
  logic       in_acc, out_acc, cfg_acc;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en && !cfg_valid && !tol_pending;
  assign cfg_ready = (in_flight == '0);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Transactions accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= 6'(in_flight + 6'(in_acc) - 6'(out_acc));
    end
  end

  // Tolerance conversion is registered and so lags a write
  always_ff @(posedge clk) begin
    if (rst) begin
      tol_pending <= 1'b0;
    end else begin
      tol_pending <= cfg_acc;
    end
  end

  // Configuration registers
  logic [15:0] tol_deg;
  logic [6:0]  joint_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_deg     <= jlvs_pkg::TOL_DEG_RESET;
      joint_count <= jlvs_pkg::JOINT_COUNT_RESET;
    end else if (cfg_acc) begin
      case (cfg_index)
        jlvs_pkg::REG_TOL_DEG:     tol_deg     <= cfg_data;
        jlvs_pkg::REG_JOINT_COUNT: joint_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Degrees to Q14 radians, rounded, never zero
  logic [40:0] tol_prod;
  logic [16:0] tol_raw;
  logic [16:0] tol;

  assign tol_prod = 41'(tol_deg) * 41'(jlvs_pkg::TOL_K) + 41'd8388608;
  assign tol_raw  = tol_prod[40:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= jlvs_pkg::TOL_RESET;
    end else begin
      tol <= (tol_raw == '0) ? 17'd1 : tol_raw;
    end
  end

  // Front stage: zone test and phase offset
  logic [6:0]         count;
  logic signed [21:0] q_e, hi_e, lo_e, tol_e, d;
  logic               up_zone, lo_zone, v_pos, v_neg, in_chain;
  jlvs_pkg::side_t    side_in;

  always_comb begin
    count    = (joint_count < MAXJ) ? joint_count : MAXJ;
    q_e      = 22'(position);
    hi_e     = 22'(upper_limit);
    lo_e     = 22'(lower_limit);
    tol_e    = $signed({5'd0, tol});
    up_zone  = (hi_e - q_e) < tol_e;
    lo_zone  = (q_e - lo_e) < tol_e;
    v_neg    = velocity[19];
    v_pos    = !velocity[19] && (velocity != '0);
    in_chain = {1'b0, joint_index} < count;
    d        = up_zone ? (q_e + tol_e - hi_e) : (q_e - tol_e - lo_e);
    side_in.vel   = velocity;
    side_in.apply = in_chain && (up_zone ? v_pos : (lo_zone && v_neg));
  end

  logic                       s0_vld;
  logic [jlvs_pkg::MAG_W-1:0] s0_mag;
  logic                       s0_neg;
  jlvs_pkg::side_t            s0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mag  <= d[21] ? 21'(-d) : 21'(d);
      s0_neg  <= d[21];
      s0_side <= side_in;
    end
  end

  // Phase divider
  logic            dv_vld;
  logic [16:0]     dv_x;
  jlvs_pkg::side_t dv_side;

  jlvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_vld),
    .in_mag   (s0_mag),
    .in_neg   (s0_neg),
    .in_side  (s0_side),
    .tol      (tol),
    .out_valid(dv_vld),
    .out_x    (dv_x),
    .out_side (dv_side)
  );

  // Multiply stages, valid bits
  logic p1_vld, p2_vld, p3_vld, p4_vld, p5_vld, p6_vld, p7_vld, p8_vld, p9_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      {p1_vld, p2_vld, p3_vld, p4_vld, p5_vld} <= '0;
      {p6_vld, p7_vld, p8_vld, p9_vld, out_valid} <= '0;
    end else if (en) begin
      p1_vld    <= dv_vld;
      p2_vld    <= p1_vld;
      p3_vld    <= p2_vld;
      p4_vld    <= p3_vld;
      p5_vld    <= p4_vld;
      p6_vld    <= p5_vld;
      p7_vld    <= p6_vld;
      p8_vld    <= p7_vld;
      p9_vld    <= p8_vld;
      out_valid <= p9_vld;
    end
  end

  // Stage payloads
  jlvs_pkg::side_t p1_side, p2_side, p3_side, p4_side, p5_side;
  jlvs_pkg::side_t p6_side, p7_side, p8_side, p9_side;
  logic [16:0] p1_x, p2_x, p3_x, p4_x;
  logic [16:0] p1_x2, p2_x2, p3_x2;
  logic [16:0] p2_t5, p3_t3, p4_t1;
  logic [16:0] p5_s, p6_g, p7_g, p7_g2, p8_g, p8_g4, p9_g5;

  logic [33:0] m1, m2, m3, m4, m5, m6, m7, m8, m9;
  logic [36:0] m10;
  logic [19:0] v_mag, r;

  assign m1 = 34'(dv_x) * 34'(dv_x);
  assign m2 = 34'(p1_x2) * 34'(jlvs_pkg::C7);
  assign m3 = 34'(p2_x2) * 34'(p2_t5);
  assign m4 = 34'(p3_x2) * 34'(p3_t3);
  assign m5 = 34'(p4_x) * 34'(p4_t1);
  assign m6 = 34'(p5_s) * 34'(p5_s);
  assign m7 = 34'(p6_g) * 34'(p6_g);
  assign m8 = 34'(p7_g2) * 34'(p7_g2);
  assign m9 = 34'(p8_g4) * 34'(p8_g);

  assign v_mag = p9_side.vel[19] ? 20'(-p9_side.vel) : 20'(p9_side.vel);
  assign m10   = 37'(v_mag) * 37'(p9_g5);
  assign r     = m10[35:16];

  always_ff @(posedge clk) begin
    if (en) begin
      // x^2
      p1_x    <= dv_x;
      p1_x2   <= m1[32:16];
      p1_side <= dv_side;
      // Horner steps of the sine polynomial
      p2_x    <= p1_x;
      p2_x2   <= p1_x2;
      p2_t5   <= 17'(jlvs_pkg::C5 - m2[32:16]);
      p2_side <= p1_side;
      p3_x    <= p2_x;
      p3_x2   <= p2_x2;
      p3_t3   <= 17'(jlvs_pkg::C3 - m3[32:16]);
      p3_side <= p2_side;
      p4_x    <= p3_x;
      p4_t1   <= 17'(jlvs_pkg::C1 - m4[32:16]);
      p4_side <= p3_side;
      // s = x * t1, clamped to one
      p5_s    <= (m5[33:16] > 18'(jlvs_pkg::ONE_Q16)) ? jlvs_pkg::ONE_Q16 : m5[32:16];
      p5_side <= p4_side;
      // g = s^2, then g^2, g^4, g^5
      p6_g    <= m6[32:16];
      p6_side <= p5_side;
      p7_g    <= p6_g;
      p7_g2   <= m7[32:16];
      p7_side <= p6_side;
      p8_g    <= p7_g;
      p8_g4   <= m8[32:16];
      p8_side <= p7_side;
      p9_g5   <= m9[32:16];
      p9_side <= p8_side;
      // Apply gain to the velocity magnitude, restore sign; else pass velocity through
      if (p9_side.apply) begin
        scaled_velocity <= p9_side.vel[19] ? $signed(20'(-r)) : $signed(r);
      end else begin
        scaled_velocity <= p9_side.vel;
      end
      was_scaled <= p9_side.apply;
    end
  end

  // Tolerance is never zero going into the divider
  a_tol_nonzero: assert property (@(posedge clk) disable iff (rst)
    tol != '0)
    else $error("tolerance is zero");

  // Gain stays within one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    p9_vld |-> p9_g5 <= jlvs_pkg::ONE_Q16)
    else $error("gain above one");

  // A stalled front stage keeps its transaction
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (s0_vld && !en) |=> (s0_vld && $stable(s0_mag) && $stable(s0_side)))
    else $error("front stage lost data under stall");

endmodule

### rtl/jlvs_div.sv
// Pipelined restoring divider giving the folded cosine phase x = |u mod 2 - 1| in Q16.
module jlvs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [jlvs_pkg::MAG_W-1:0]    in_mag,
  input  logic                          in_neg,
  input  jlvs_pkg::side_t               in_side,
  input  logic [16:0]                   tol,
  output logic                          out_valid,
  output logic [16:0]                   out_x,
  output jlvs_pkg::side_t               out_side
);

  localparam int NS = jlvs_pkg::DIVD_W;

  logic                     vld  [NS];
  logic [16:0]              rem  [NS];
  logic [NS-1:0]            dvd  [NS];
  logic [16:0]              quo  [NS];
  logic                     neg  [NS];
  jlvs_pkg::side_t          side [NS];

  logic [16:0]              src_rem  [NS];
  logic [NS-1:0]            src_dvd  [NS];
  logic [16:0]              src_quo  [NS];
  logic [17:0]              trial    [NS];
  logic [16:0]              rem_next [NS];
  logic [16:0]              quo_next [NS];

  // One quotient bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_comb begin
        src_rem[i] = '0;
        src_dvd[i] = {in_mag, 16'd0};
        src_quo[i] = '0;
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en) begin
          vld[i] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          neg[i]  <= in_neg;
          side[i] <= in_side;
        end
      end
    end else begin : g_rest
      always_comb begin
        src_rem[i] = rem[i-1];
        src_dvd[i] = dvd[i-1];
        src_quo[i] = quo[i-1];
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en) begin
          vld[i] <= vld[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          neg[i]  <= neg[i-1];
          side[i] <= side[i-1];
        end
      end
    end

    // Shift in the next dividend bit, subtract tol when it fits
    always_comb begin
      trial[i] = {src_rem[i], src_dvd[i][NS-1]};
      if (trial[i] >= {1'b0, tol}) begin
        rem_next[i] = 17'(trial[i] - {1'b0, tol});
        quo_next[i] = {src_quo[i][15:0], 1'b1};
      end else begin
        rem_next[i] = trial[i][16:0];
        quo_next[i] = {src_quo[i][15:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= rem_next[i];
        quo[i] <= quo_next[i];
        dvd[i] <= src_dvd[i] << 1;
      end
    end
  end

  // Floor for negative phase, then fold to distance from the half turn
  logic [16:0] u;
  logic [16:0] x_next;

  always_comb begin
    if (neg[NS-1]) begin
      u = 17'(-(quo[NS-1] + 17'(rem[NS-1] != '0)));
    end else begin
      u = quo[NS-1];
    end
    if (u[16]) begin
      x_next = {1'b0, u[15:0]};
    end else begin
      x_next = 17'(jlvs_pkg::ONE_Q16 - u);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_side <= side[NS-1];
    end
  end

  // Folded phase never exceeds one quarter turn
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_x <= jlvs_pkg::ONE_Q16)
    else $error("folded phase out of range");

  // Final remainder is below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[NS-1] |-> rem[NS-1] < tol)
    else $error("divider remainder out of range");

  // Output register holds under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !en) |=> (out_valid && $stable(out_x) && $stable(out_side)))
    else $error("divider output lost under stall");

endmodule
